/* design/b64sd_pkg.sv */
// shared types, constants and the character map of the strict base64 decoder
// no dependencies
`default_nettype none

package b64sd_pkg;

    // result status codes
    localparam logic [2:0] ST_BYTE      = 3'd0;
    localparam logic [2:0] ST_TEXT_OK   = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_PAD_PLACE = 3'd3;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd4;
    localparam logic [2:0] ST_PAD_BITS  = 3'd5;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one decoded quartet or status: up to three bytes then an optional status
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [1:0] nbytes;
        logic       has_status;
        logic [2:0] status;
    } job_t;

    // bit 6 set: not a sextet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2b) begin
            r = {1'b0, 6'd62};
        end else if (c == 8'h2f) begin
            r = {1'b0, 6'd63};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/base64_strict_decoder_top.sv */
// top level of the strict base64 decoder: front end, job queue and result sequencer
// depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back
`default_nettype none

// strict base64 decoder, standard alphabet with required padding. one character
// request is taken per cycle on s_* while s_ready is high; s_end_of_text marks
// the last character of a text. each good quartet gives one to three byte results
// (status 0), and the last character of a text gives one status result with
// m_frame_done set (1 ok, 2 length, 3 padding place, 4 bad char, 5 padding bits).
// after an error the rest of the text is dropped until its last character. bytes
// of earlier quartets may already be out, so discard any text that ends in an
// error.
// timing: a character is classified in the cycle it is accepted and its job
// enters the queue at that edge; with an idle output the sequencer loads it into
// its job register on the next edge and offers its first result on m_* from
// there, then one per cycle while m_ready is high. the front end keeps taking one
// character per cycle as long as the four-entry job queue has room, and a quartet
// of four characters gives at most four results (three bytes, plus one status on
// the last quartet). output stalls back up into s_ready only once four jobs
// (decoded quartets or text statuses) wait in the queue behind the one being sent.

module base64_strict_decoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic [2:0]      m_status,
    output logic            m_frame_done
);
    import b64sd_pkg::*;

    job_t front_job;
    job_t head_job;
    logic front_push;
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    logic in_fire;

    // the queue only refuses when full, so the front end never stalls on its own
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    b64sd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .char_code   (s_char_code),
        .end_of_text (s_end_of_text),
        .job         (front_job),
        .job_push    (front_push)
    );

    // jobs carry whole quartets, so a request pushes at most one entry
    b64sd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_job  (front_job),
        .pop       (q_pop),
        .head_job  (head_job),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // serializes bytes then the optional status of each job
    b64sd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_job     (head_job),
        .q_not_empty  (q_not_empty),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_status     (m_status),
        .m_frame_done (m_frame_done)
    );

endmodule

`default_nettype wire

/* design/b64sd_front.sv */
// front end: takes characters, tracks quartet state, checks quartets, builds jobs
// depends on b64sd_pkg
`default_nettype none

module b64sd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic [7:0]    char_code,
    input  wire logic          end_of_text,
    output b64sd_pkg::job_t    job,
    output logic               job_push
);
    import b64sd_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] accum_reg, accum_next;
    logic        lead_inv_reg, lead_inv_next;
    logic        third_pad_reg, third_pad_next;
    logic        third_inv_reg, third_inv_next;
    logic        swallow_reg, swallow_next;

    logic [6:0]  sx;
    logic        bad;
    logic [5:0]  sv;
    logic        is_pad;
    logic [23:0] value;
    logic [2:0]  code;

    always_comb begin
        sx     = sextet_of(char_code);
        bad    = sx[6];
        sv     = sx[5:0];
        is_pad = (char_code == PAD_CHAR);
        value  = {accum_reg, (is_pad ? 6'd0 : sv)};

        // quartet checks in priority order
        if ((third_pad_reg && !is_pad) || ((third_pad_reg || is_pad) && !end_of_text)) begin
            code = ST_PAD_PLACE;
        end else if (lead_inv_reg || third_inv_reg || (!is_pad && bad)) begin
            code = ST_BAD_CHAR;
        end else if ((third_pad_reg && value[15:0] != 16'd0) ||
                     (is_pad && !third_pad_reg && value[7:0] != 8'd0)) begin
            code = ST_PAD_BITS;
        end else begin
            code = ST_BYTE;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        accum_next     = accum_reg;
        lead_inv_next  = lead_inv_reg;
        third_pad_next = third_pad_reg;
        third_inv_next = third_inv_reg;
        swallow_next   = swallow_reg;
        job_push       = 1'b0;
        job            = '0;

        if (in_fire) begin
            if (swallow_reg) begin
                if (end_of_text) begin
                    job_push       = 1'b1;
                    job.has_status = 1'b1;
                    job.status     = (pos_reg == 2'd3) ? accum_reg[2:0] : ST_LENGTH;
                    pos_next       = '0;
                    accum_next     = '0;
                    lead_inv_next  = 1'b0;
                    third_pad_next = 1'b0;
                    third_inv_next = 1'b0;
                    swallow_next   = 1'b0;
                end else begin
                    pos_next = pos_reg + 2'd1;
                end
            end else if (end_of_text && pos_reg != 2'd3) begin
                job_push       = 1'b1;
                job.has_status = 1'b1;
                job.status     = ST_LENGTH;
                pos_next       = '0;
                accum_next     = '0;
                lead_inv_next  = 1'b0;
                third_pad_next = 1'b0;
                third_inv_next = 1'b0;
            end else begin
                case (pos_reg)
                    2'd0: begin
                        lead_inv_next = bad;
                        accum_next    = {12'd0, sv};
                        pos_next      = 2'd1;
                    end
                    2'd1: begin
                        lead_inv_next = lead_inv_reg | bad;
                        accum_next    = {accum_reg[11:0], sv};
                        pos_next      = 2'd2;
                    end
                    2'd2: begin
                        third_pad_next = is_pad;
                        third_inv_next = !is_pad && bad;
                        accum_next     = {accum_reg[11:0], (is_pad ? 6'd0 : sv)};
                        pos_next       = 2'd3;
                    end
                    default: begin
                        pos_next       = '0;
                        accum_next     = '0;
                        lead_inv_next  = 1'b0;
                        third_pad_next = 1'b0;
                        third_inv_next = 1'b0;
                        if (code != ST_BYTE) begin
                            if (end_of_text) begin
                                job_push       = 1'b1;
                                job.has_status = 1'b1;
                                job.status     = code;
                            end else begin
                                swallow_next = 1'b1;
                                accum_next   = {15'd0, code};
                            end
                        end else begin
                            job_push       = 1'b1;
                            job.data0      = value[23:16];
                            job.data1      = value[15:8];
                            job.data2      = value[7:0];
                            job.nbytes     = 2'd3 - {1'b0, third_pad_reg} - {1'b0, is_pad};
                            job.has_status = end_of_text;
                            job.status     = ST_TEXT_OK;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            accum_reg     <= '0;
            lead_inv_reg  <= 1'b0;
            third_pad_reg <= 1'b0;
            third_inv_reg <= 1'b0;
            swallow_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            accum_reg     <= accum_next;
            lead_inv_reg  <= lead_inv_next;
            third_pad_reg <= third_pad_next;
            third_inv_reg <= third_inv_next;
            swallow_reg   <= swallow_next;
        end
    end

endmodule

`default_nettype wire

/* design/b64sd_queue.sv */
// short job queue between the front end and the result sequencer
// depends on b64sd_pkg
`default_nettype none

module b64sd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire b64sd_pkg::job_t push_job,
    input  wire logic          pop,
    output b64sd_pkg::job_t    head_job,
    output logic               not_empty,
    output logic               full
);
    import b64sd_pkg::*;

    job_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb begin
        full      = (count_reg == QCNT_W'(QDEPTH));
        not_empty = (count_reg != '0);
        head_job  = entries_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/b64sd_back.sv */
// back end: walks one job at a time and hands out its results one per cycle while m_ready is high
// depends on b64sd_pkg
`default_nettype none

module b64sd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire b64sd_pkg::job_t head_job,
    input  wire logic          q_not_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_data_byte,
    output logic [2:0]         m_status,
    output logic               m_frame_done
);
    import b64sd_pkg::*;

    job_t       cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] n_results;
    logic       is_byte;
    logic       fire, last_result;

    always_comb begin
        n_results   = {1'b0, cur_reg.nbytes} + {2'd0, cur_reg.has_status};
        is_byte     = (idx_reg < cur_reg.nbytes);
        fire        = busy_reg && m_ready;
        last_result = ({1'b0, idx_reg} + 3'd1 == n_results);

        m_valid      = busy_reg;
        m_frame_done = !is_byte;
        m_status     = is_byte ? ST_BYTE : cur_reg.status;
        case (idx_reg)
            2'd0:    m_data_byte = cur_reg.data0;
            2'd1:    m_data_byte = cur_reg.data1;
            2'd2:    m_data_byte = cur_reg.data2;
            default: m_data_byte = 8'd0;
        endcase
        if (!is_byte) begin
            m_data_byte = 8'd0;
        end

        q_pop     = !busy_reg || (fire && last_result);
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            busy_next = q_not_empty;
            cur_next  = head_job;
            idx_next  = '0;
        end else if (fire) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* design/b64sd_checker.sv */
// port-level checks for the strict base64 decoder, bound to the top level
// depends on b64sd_pkg and base64_strict_decoder_top
`default_nettype none

module b64sd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_data_byte,
    input wire logic [2:0] m_status,
    input wire logic       m_frame_done
);
    import b64sd_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // byte results never close a text
    a_byte_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BYTE |-> !m_frame_done)
        else $error("byte result marked as end of text");

    // status results close the text and carry a zero byte
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_BYTE |-> m_frame_done && m_data_byte == 8'd0)
        else $error("status result malformed");

    // only defined status codes appear
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_PAD_BITS)
        else $error("undefined status code");

endmodule

bind base64_strict_decoder_top b64sd_checker u_b64sd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_data_byte  (m_data_byte),
    .m_status     (m_status),
    .m_frame_done (m_frame_done)
);

`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for base64_strict_decoder_top: drives character requests
// and compares every result with a built-in strict base64 decode of the same stream
// depends on b64sd_pkg and the design files under design/
module tb;
    import b64sd_pkg::*;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       frame_done;
    } dec_result_t;

    // no request moving on either side for this many cycles means the block hung
    localparam int HANG_LIMIT = 1000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_byte;
    logic [2:0] m_status;
    logic       m_frame_done;

    // decoded results still owed by the block, oldest first
    dec_result_t pending_results[$];

    // shadow of the decoder state
    logic [1:0]  dec_pos;
    logic [17:0] dec_acc;
    logic        dec_lead_bad;
    logic        dec_third_pad;
    logic        dec_third_bad;
    logic        dec_dropping;

    int  mismatches = 0;
    int  chars_sent = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b0;

    base64_strict_decoder_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_status      (m_status),
        .m_frame_done  (m_frame_done)
    );

    // 12 unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // decode of the character stream
    // ---------------------------------------------------------------

    // bit 6 flags a character outside the alphabet
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) return {1'b0, 6'(c - 8'h41)};
        if (c >= 8'h61 && c <= 8'h7a) return {1'b0, 6'(c - 8'h61 + 8'd26)};
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
        if (c == 8'h2b) return 7'd62;
        if (c == 8'h2f) return 7'd63;
        return 7'h40;
    endfunction

    // alphabet character for a sextet, used to build texts
    function automatic logic [7:0] sextet_char(input int unsigned v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return 8'h2b;
        return 8'h2f;
    endfunction

    function automatic void clear_decoder();
        dec_pos       = 2'd0;
        dec_acc       = 18'd0;
        dec_lead_bad  = 1'b0;
        dec_third_pad = 1'b0;
        dec_third_bad = 1'b0;
        dec_dropping  = 1'b0;
    endfunction

    function automatic void owe(input logic [7:0] b, input logic [2:0] st, input logic done);
        dec_result_t r;
        r.data_byte  = b;
        r.status     = st;
        r.frame_done = done;
        pending_results = {pending_results, r};
    endfunction

    // one accepted character: update the shadow state and queue what it causes
    function automatic void decode_char(input logic [7:0] c, input logic last);
        logic [6:0]  sx;
        logic        bad;
        logic [5:0]  sv;
        logic        fourth_pad;
        logic        fourth_bad;
        logic [23:0] word;
        logic [2:0]  code;
        sx  = char_to_sextet(c);
        bad = sx[6];
        sv  = bad ? 6'd0 : sx[5:0];
        if (dropping_check(last)) begin
            // handled inside: error already pending for this text
        end else if (last && dec_pos != 2'd3) begin
            owe(8'h00, ST_LENGTH, 1'b1);
            clear_decoder();
        end else begin
            case (dec_pos)
                2'd0: begin
                    dec_lead_bad = bad;
                    dec_acc      = {12'd0, sv};
                    dec_pos      = 2'd1;
                end
                2'd1: begin
                    dec_lead_bad = dec_lead_bad | bad;
                    dec_acc      = {dec_acc[11:0], sv};
                    dec_pos      = 2'd2;
                end
                2'd2: begin
                    dec_third_pad = (c == PAD_CHAR);
                    dec_third_bad = !dec_third_pad && bad;
                    dec_acc       = {dec_acc[11:0], dec_third_pad ? 6'd0 : sv};
                    dec_pos       = 2'd3;
                end
                default: begin
                    fourth_pad = (c == PAD_CHAR);
                    fourth_bad = !fourth_pad && bad;
                    word       = {dec_acc, fourth_pad ? 6'd0 : sv};
                    code       = ST_BYTE;
                    // checks run in priority order: placement, alphabet, leftover bits
                    if ((dec_third_pad && !fourth_pad) ||
                        ((dec_third_pad || fourth_pad) && !last)) begin
                        code = ST_PAD_PLACE;
                    end else if (dec_lead_bad || dec_third_bad || fourth_bad) begin
                        code = ST_BAD_CHAR;
                    end else if ((dec_third_pad && word[15:0] != 16'd0) ||
                                 (fourth_pad && !dec_third_pad && word[7:0] != 8'd0)) begin
                        code = ST_PAD_BITS;
                    end
                    if (code != ST_BYTE) begin
                        if (last) begin
                            owe(8'h00, code, 1'b1);
                            clear_decoder();
                        end else begin
                            // remember the error and swallow the rest of the text
                            clear_decoder();
                            dec_dropping = 1'b1;
                            dec_acc      = {15'd0, code};
                        end
                    end else begin
                        owe(word[23:16], ST_BYTE, 1'b0);
                        if (!dec_third_pad) owe(word[15:8], ST_BYTE, 1'b0);
                        if (!fourth_pad) owe(word[7:0], ST_BYTE, 1'b0);
                        if (last) owe(8'h00, ST_TEXT_OK, 1'b1);
                        clear_decoder();
                    end
                end
            endcase
        end
    endfunction

    // while an error is pending only the position advances; the last character
    // reports the held status, or a length error if it falls off the quartet grid
    function automatic bit dropping_check(input logic last);
        if (!dec_dropping) return 1'b0;
        if (last) begin
            owe(8'h00, (dec_pos == 2'd3) ? dec_acc[2:0] : ST_LENGTH, 1'b1);
            clear_decoder();
        end else begin
            dec_pos = dec_pos + 2'd1;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with s_valid still high
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_end_of_text <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_char(c, last);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input char_q_t txt);
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    function automatic char_q_t text_of(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
        return q;
    endfunction

    // well-formed encoding of nbytes random bytes, padding included
    task automatic build_text(input int nbytes, output char_q_t txt);
        logic [23:0] w;
        int          left;
        txt = {};
        for (int i = 0; i < nbytes; i += 3) begin
            left = nbytes - i;
            w = {8'($urandom), (left > 1) ? 8'($urandom) : 8'h00,
                 (left > 2) ? 8'($urandom) : 8'h00};
            txt = {txt, sextet_char(w[23:18])};
            txt = {txt, sextet_char(w[17:12])};
            txt = {txt, (left > 1) ? sextet_char(w[11:6]) : PAD_CHAR};
            txt = {txt, (left > 2) ? sextet_char(w[5:0]) : PAD_CHAR};
        end
    endtask

    // damage a good text in one of several ways
    task automatic break_text(inout char_q_t txt);
        char_q_t extra;
        int      idx;
        idx = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 5))
            0: txt[idx] = 8'($urandom);
            1: txt[idx] = PAD_CHAR;
            2: if (txt.size() > 1) void'(txt.pop_back());
            3: txt = {txt, sextet_char($urandom_range(0, 63))};
            4: begin
                // another good text appended, so a padded quartet can be followed by more text
                build_text($urandom_range(1, 6), extra);
                foreach (extra[i]) txt = {txt, extra[i]};
            end
            default: txt[idx] = txt[idx] ^ (8'h01 << $urandom_range(0, 7));
        endcase
    endtask

    // random characters, biased toward the alphabet and padding
    task automatic noise_text(output char_q_t txt);
        int n;
        int pick;
        txt = {};
        n = $urandom_range(1, 9);
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) txt = {txt, sextet_char($urandom_range(0, 63))};
            else if (pick < 13) txt = {txt, PAD_CHAR};
            else txt = {txt, 8'($urandom)};
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // back-pressure in bursts while idling is enabled; m_ready stays high otherwise
    always @(negedge aclk) begin
        if (!idle_on) begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest one owed
    always @(posedge aclk) begin
        dec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: data_byte %0h status %0d frame_done %0b",
                       m_data_byte, m_status, m_frame_done);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, m_data_byte);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done, m_frame_done);
                    mismatches++;
                end
            end
        end
    end

    // hang detection: count cycles in which no request moves on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // hand-picked texts: every status, the alphabet edges A, Z, a, z, 9, + and /, and codes 0x00 and 0xff
    task automatic test_directed();
        send_text(text_of("Zm9v"));         // three bytes, text ok
        send_text(text_of("+/8="));         // two bytes, '+' and '/'
        send_text(text_of("Az=="));         // leftover bits under double padding
        send_text(text_of("QQ=A"));         // '=' third without '=' fourth
        send_text(text_of("QQ==Zg"));       // padding before the end, then short length
        send_char(8'h00, 1'b0);             // short text with codes outside the alphabet
        send_char(8'hff, 1'b1);
        send_text(text_of("=a9/"));         // padding up front is a bad character
    endtask

    // mostly well-formed texts with random content, plus damaged texts and noise
    task automatic test_random_texts(input int budget);
        char_q_t txt;
        int      stop_at;
        int      kind;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) begin
            // some texts run with no idling at all
            idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                build_text($urandom_range(1, 9), txt);
            end else if (kind < 18) begin
                build_text($urandom_range(1, 9), txt);
                break_text(txt);
            end else begin
                noise_text(txt);
            end
            send_text(txt);
        end
    endtask

    // hold the request side until every owed result has come back
    task automatic test_drain_pause();
        char_q_t txt;
        idle_on = 1'b1;
        repeat (3) begin
            repeat (3) begin
                build_text($urandom_range(1, 6), txt);
                send_text(txt);
            end
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate(input int budget);
        char_q_t txt;
        int      stop_at;
        idle_on = 1'b0;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) begin
            build_text($urandom_range(1, 9), txt);
            if ($urandom_range(0, 3) == 0) break_text(txt);
            send_text(txt);
        end
    endtask

    initial begin
        clear_decoder();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_texts(340);
        test_drain_pause();
        test_full_rate(60);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
